@@ hdl/bm3p_pkg.sv @@
// ----------------------------------------------------------------------------
// bm3p_pkg
// Shared codes, field widths and the control bundle passed from the
// sequencer to the arithmetic path of the 3x3 box mean block.
// ----------------------------------------------------------------------------
package bm3p_pkg;

    // configuration port layout
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int WIDTH_FIELD_W = 11;
    localparam int HEIGHT_W      = 16;
    localparam int FILTER_W      = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER = 2'd2;

    // neighbour selection modes
    localparam logic [FILTER_W-1:0] FILT_ALL  = 2'd0;
    localparam logic [FILTER_W-1:0] FILT_EVEN = 2'd1;
    localparam logic [FILTER_W-1:0] FILT_ODD  = 2'd2;
    localparam logic [FILTER_W-1:0] FILT_NONE = 2'd3;

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // sequencer to arithmetic path
    typedef struct packed {
        logic                acc_clear;  // start a new neighbourhood
        logic                tag_vld;    // read data arrives this cycle
        logic                tag_ok;     // that neighbour lies inside the frame
        logic                tag_last;   // that neighbour is the ninth
        logic [FILTER_W-1:0] filter;
        logic                row_end;
        logic                frame_end;
    } t_dp_ctl;

endpackage

@@ hdl/bm3p_ram.sv @@
// ----------------------------------------------------------------------------
// bm3p_ram
// Generic single-clock RAM, one write port and one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module bm3p_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/bm3p_ctrl.sv @@
// ----------------------------------------------------------------------------
// bm3p_ctrl
// Stream position tracking, release decision and the read sequencer that
// walks the nine neighbours of the oldest pending pixel through the
// history memory.
// ----------------------------------------------------------------------------
module bm3p_ctrl #(
    parameter int  MAX_WIDTH  = 1024,
    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 4,
    localparam int ADDR_W     = $clog2(HIST_DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    input  logic [bm3p_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [bm3p_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_cfg_ready,
    // input channel handshake
    input  logic                              i_in_valid,
    input  logic                              i_kind,
    output logic                              o_in_stall,
    // history memory
    output logic                              o_wr_en,
    output logic [ADDR_W-1:0]                 o_wr_addr,
    output logic                              o_rd_en,
    output logic [ADDR_W-1:0]                 o_rd_addr,
    // arithmetic path
    output bm3p_pkg::t_dp_ctl                 o_dp,
    input  logic                              i_done
);

    localparam int WEFF_W  = $clog2(MAX_WIDTH + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int PEND_W  = $clog2(MAX_WIDTH + 3);
    localparam int CMP_W   = (WEFF_W > bm3p_pkg::WIDTH_FIELD_W) ? WEFF_W
                                                                : bm3p_pkg::WIDTH_FIELD_W;
    localparam int RST_WIDTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int H_W     = bm3p_pkg::HEIGHT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_FINISH
    } t_state;

    t_state                          r_state;
    logic [WEFF_W-1:0]               r_w_eff;
    logic [H_W-1:0]                  r_h_eff;
    logic [bm3p_pkg::FILTER_W-1:0]   r_filter;
    logic [ADDR_W-1:0]               r_wr_pos;
    logic [PEND_W-1:0]               r_pending;
    logic [PEND_W-1:0]               r_recv;
    logic [COL_W-1:0]                r_in_col;
    logic [H_W-1:0]                  r_in_row;
    logic [COL_W-1:0]                r_out_col;
    logic [H_W-1:0]                  r_out_row;
    logic [ADDR_W-1:0]               r_base;
    logic [ADDR_W-1:0]               r_addr;
    logic [1:0]                      r_dr;
    logic [1:0]                      r_dc;
    logic [2:0]                      r_row_ok;
    logic [2:0]                      r_col_ok;
    logic                            r_row_end;
    logic                            r_frame_end;
    logic                            r_acc_clear;
    logic                            r_tag_vld;
    logic                            r_tag_ok;
    logic                            r_tag_last;

    logic                            in_acc;
    logic                            pix_acc;
    logic                            cfg_wr;
    logic                            cfg_hit;
    logic [bm3p_pkg::WIDTH_FIELD_W-1:0] wf;
    logic [CMP_W-1:0]                wf_ext;
    logic [WEFF_W-1:0]               cfg_w_eff;
    logic [H_W-1:0]                  cfg_h_eff;
    logic [WEFF_W-1:0]               w_m1;
    logic [H_W-1:0]                  h_m1;
    logic                            in_col_last;
    logic                            in_row_last;
    logic                            out_col_last;
    logic                            out_row_last;
    logic                            old_frame;
    logic                            release_ok;
    logic [ADDR_W-1:0]               span;
    logic [ADDR_W-1:0]               base0;
    logic [ADDR_W:0]                 base_sum;
    logic [ADDR_W-1:0]               base_next;
    logic [ADDR_W-1:0]               addr_inc;
    logic [ADDR_W-1:0]               wr_pos_inc;
    logic                            slot_ok;
    logic                            slot_last;

    // handshakes, an offered register write holds off input items
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign pix_acc     = in_acc && (i_kind == bm3p_pkg::KIND_PIXEL);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_wr && ((i_cfg_index == bm3p_pkg::CFG_WIDTH)
                                 || (i_cfg_index == bm3p_pkg::CFG_HEIGHT)
                                 || (i_cfg_index == bm3p_pkg::CFG_FILTER));

    // effective frame size from written values
    assign wf        = i_cfg_data[bm3p_pkg::WIDTH_FIELD_W-1:0];
    assign wf_ext    = CMP_W'(wf);
    assign cfg_w_eff = (wf == '0) ? WEFF_W'(1)
                     : (wf_ext > CMP_W'(MAX_WIDTH)) ? WEFF_W'(MAX_WIDTH)
                     : WEFF_W'(wf_ext);
    assign cfg_h_eff = (i_cfg_data[H_W-1:0] == '0) ? H_W'(1) : i_cfg_data[H_W-1:0];

    // position compares
    assign w_m1         = r_w_eff - WEFF_W'(1);
    assign h_m1         = r_h_eff - H_W'(1);
    assign in_col_last  = (WEFF_W'(r_in_col) == w_m1);
    assign in_row_last  = (r_in_row == h_m1);
    assign out_col_last = (WEFF_W'(r_out_col) == w_m1);
    assign out_row_last = (r_out_row == h_m1);

    // oldest result is releasable once its frame is complete or the pixel
    // one row and one column past it has arrived
    assign old_frame  = (r_pending > r_recv);
    assign release_ok = (r_pending != '0)
                     && (old_frame || (r_pending >= PEND_W'(r_w_eff) + PEND_W'(2)));

    // top-left neighbour address, wrapped into the history ring
    assign span  = ADDR_W'(r_pending) + ADDR_W'(r_w_eff) + ADDR_W'(1);
    assign base0 = (r_wr_pos >= span) ? (r_wr_pos - span)
                                      : (r_wr_pos - span + ADDR_W'(HIST_DEPTH));

    // address stepping
    assign base_sum   = {1'b0, r_base} + (ADDR_W+1)'(r_w_eff);
    assign base_next  = (base_sum >= (ADDR_W+1)'(HIST_DEPTH))
                      ? ADDR_W'(base_sum - (ADDR_W+1)'(HIST_DEPTH))
                      : ADDR_W'(base_sum);
    assign addr_inc   = (r_addr == ADDR_W'(HIST_DEPTH - 1)) ? '0 : r_addr + ADDR_W'(1);
    assign wr_pos_inc = (r_wr_pos == ADDR_W'(HIST_DEPTH - 1)) ? '0 : r_wr_pos + ADDR_W'(1);

    assign slot_ok   = r_row_ok[r_dr] & r_col_ok[r_dc];
    assign slot_last = (r_dr == 2'd2) && (r_dc == 2'd2);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_w_eff     <= WEFF_W'(RST_WIDTH);
            r_h_eff     <= H_W'(1024);
            r_filter    <= bm3p_pkg::FILT_ALL;
            r_wr_pos    <= '0;
            r_pending   <= '0;
            r_recv      <= '0;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_acc_clear <= 1'b0;
            r_tag_vld   <= 1'b0;
            r_tag_ok    <= 1'b0;
            r_tag_last  <= 1'b0;
            r_base      <= '0;
            r_addr      <= '0;
            r_dr        <= '0;
            r_dc        <= '0;
            r_row_ok    <= '0;
            r_col_ok    <= '0;
            r_row_end   <= 1'b0;
            r_frame_end <= 1'b0;
        end else begin
            // accumulator clear and read tag follow the sequencer state
            r_acc_clear <= (r_state == S_DECIDE) && release_ok;
            r_tag_vld   <= (r_state == S_READ);

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (pix_acc) begin
                            r_wr_pos  <= wr_pos_inc;
                            r_pending <= r_pending + PEND_W'(1);
                            if (in_col_last) begin
                                r_in_col <= '0;
                                if (in_row_last) begin
                                    r_in_row <= '0;
                                    r_recv   <= '0;
                                end else begin
                                    r_in_row <= r_in_row + H_W'(1);
                                    r_recv   <= (r_recv == '1) ? r_recv
                                                               : r_recv + PEND_W'(1);
                                end
                            end else begin
                                r_in_col <= r_in_col + COL_W'(1);
                                r_recv   <= (r_recv == '1) ? r_recv : r_recv + PEND_W'(1);
                            end
                        end
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (release_ok) begin
                        r_row_end   <= out_col_last;
                        r_frame_end <= out_col_last && out_row_last;
                        r_row_ok    <= {!out_row_last, 1'b1, (r_out_row != '0)};
                        r_col_ok    <= {!out_col_last, 1'b1, (r_out_col != '0)};
                        r_base      <= base0;
                        r_addr      <= base0;
                        r_dr        <= '0;
                        r_dc        <= '0;
                        r_pending   <= r_pending - PEND_W'(1);
                        if (out_col_last) begin
                            r_out_col <= '0;
                            r_out_row <= out_row_last ? '0 : r_out_row + H_W'(1);
                        end else begin
                            r_out_col <= r_out_col + COL_W'(1);
                        end
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    // one neighbour read per cycle, tag follows the read data
                    r_tag_ok   <= slot_ok;
                    r_tag_last <= slot_last;
                    if (r_dc == 2'd2) begin
                        r_dc   <= '0;
                        r_dr   <= r_dr + 2'd1;
                        r_base <= base_next;
                        r_addr <= base_next;
                    end else begin
                        r_dc   <= r_dc + 2'd1;
                        r_addr <= addr_inc;
                    end
                    if (slot_last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // a register write restarts the stream
            if (cfg_hit) begin
                unique case (i_cfg_index)
                    bm3p_pkg::CFG_WIDTH:  r_w_eff  <= cfg_w_eff;
                    bm3p_pkg::CFG_HEIGHT: r_h_eff  <= cfg_h_eff;
                    bm3p_pkg::CFG_FILTER: r_filter <= i_cfg_data[bm3p_pkg::FILTER_W-1:0];
                    default: ;
                endcase
                r_wr_pos  <= '0;
                r_pending <= '0;
                r_recv    <= '0;
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end
        end
    end

    // memory ports
    assign o_wr_en   = pix_acc;
    assign o_wr_addr = r_wr_pos;
    assign o_rd_en   = (r_state == S_READ);
    assign o_rd_addr = r_addr;

    // control bundle
    always_comb begin
        o_dp.acc_clear = r_acc_clear;
        o_dp.tag_vld   = r_tag_vld;
        o_dp.tag_ok    = r_tag_ok;
        o_dp.tag_last  = r_tag_last;
        o_dp.filter    = r_filter;
        o_dp.row_end   = r_row_end;
        o_dp.frame_end = r_frame_end;
    end

endmodule

@@ hdl/bm3p_dp.sv @@
// ----------------------------------------------------------------------------
// bm3p_dp
// Sum and count of the qualifying neighbours, mean by reciprocal multiply
// and the output register towards the result channel.
// ----------------------------------------------------------------------------
module bm3p_dp #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bm3p_pkg::t_dp_ctl     i_dp,
    input  logic [PIXEL_BITS-1:0] i_rd_data,
    output logic                  o_done,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIXEL_BITS-1:0] o_mean_value,
    output logic                  o_row_end,
    output logic                  o_frame_end
);

    localparam int SUM_W   = PIXEL_BITS + 4;
    localparam int K       = PIXEL_BITS + 7;
    localparam int RECIP_W = K + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint ONE_K = longint'(1) << K;

    // ceil(2^K / n), exact for every sum of up to nine pixels
    localparam logic [RECIP_W-1:0] RC1 = RECIP_W'(ONE_K);
    localparam logic [RECIP_W-1:0] RC2 = RECIP_W'((ONE_K + 1) / 2);
    localparam logic [RECIP_W-1:0] RC3 = RECIP_W'((ONE_K + 2) / 3);
    localparam logic [RECIP_W-1:0] RC4 = RECIP_W'((ONE_K + 3) / 4);
    localparam logic [RECIP_W-1:0] RC5 = RECIP_W'((ONE_K + 4) / 5);
    localparam logic [RECIP_W-1:0] RC6 = RECIP_W'((ONE_K + 5) / 6);
    localparam logic [RECIP_W-1:0] RC7 = RECIP_W'((ONE_K + 6) / 7);
    localparam logic [RECIP_W-1:0] RC8 = RECIP_W'((ONE_K + 7) / 8);
    localparam logic [RECIP_W-1:0] RC9 = RECIP_W'((ONE_K + 8) / 9);

    logic [SUM_W-1:0]      r_sum;
    logic [3:0]            r_cnt;
    logic                  r_mul_go;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_prod_vld;
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_mean;
    logic                  r_row_end;
    logic                  r_frame_end;

    logic                  qual;
    logic                  take;
    logic [RECIP_W-1:0]    recip;
    logic [PROD_W-1:0]     prod;
    logic                  load;

    // parity selection of one neighbour
    always_comb begin
        unique case (i_dp.filter)
            bm3p_pkg::FILT_ALL:  qual = 1'b1;
            bm3p_pkg::FILT_EVEN: qual = !i_rd_data[0];
            bm3p_pkg::FILT_ODD:  qual = i_rd_data[0];
            bm3p_pkg::FILT_NONE: qual = 1'b0;
            default:             qual = 1'b0;
        endcase
    end

    assign take = i_dp.tag_vld && i_dp.tag_ok && qual;

    // reciprocal of the neighbour count, zero count gives zero
    always_comb begin
        unique case (r_cnt)
            4'd1:    recip = RC1;
            4'd2:    recip = RC2;
            4'd3:    recip = RC3;
            4'd4:    recip = RC4;
            4'd5:    recip = RC5;
            4'd6:    recip = RC6;
            4'd7:    recip = RC7;
            4'd8:    recip = RC8;
            4'd9:    recip = RC9;
            default: recip = '0;
        endcase
    end

    assign prod = PROD_W'(r_sum) * PROD_W'(recip);
    assign load = r_prod_vld && (!r_out_valid || !i_out_stall);

    // accumulation and result payload
    always_ff @(posedge i_clk) begin
        if (i_dp.acc_clear) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (take) begin
            r_sum <= r_sum + SUM_W'(i_rd_data);
            r_cnt <= r_cnt + 4'd1;
        end
        if (r_mul_go) begin
            r_prod <= prod;
        end
        if (load) begin
            r_mean      <= r_prod[K +: PIXEL_BITS];
            r_row_end   <= i_dp.row_end;
            r_frame_end <= i_dp.frame_end;
        end
    end

    // pipeline and output handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_go    <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_go <= i_dp.tag_vld && i_dp.tag_last;
            if (r_mul_go) begin
                r_prod_vld <= 1'b1;
            end else if (load) begin
                r_prod_vld <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_done       = load;
    assign o_out_valid  = r_out_valid;
    assign o_mean_value = r_mean;
    assign o_row_end    = r_row_end;
    assign o_frame_end  = r_frame_end;

endmodule

@@ hdl/box_mean_3x3_parity.sv @@
// ----------------------------------------------------------------------------
// box_mean_3x3_parity
// 3x3 box mean over a raster pixel stream with optional even or odd
// neighbour selection, built around a ring history memory.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are written into a ring memory of
// 2*MAX_WIDTH+4 entries; each result is the floor mean of the in-frame
// neighbours of the oldest pending pixel and comes out one row plus one
// pixel behind the input, with drain items releasing the tail of a frame.
// An item that releases a result occupies the block while it is accepted,
// while it decides and forms the first address, while it reads the nine
// neighbours one at a time through the single read port of the memory, and
// while it finishes the sum, multiplies by the reciprocal of the count and
// loads the output register. An item that releases nothing is only
// accepted and decided. The output register lets the next item in while a
// result waits to be taken. A register write restarts the stream and drops
// pending results; input items are held off while a register write is offered.
module box_mean_3x3_parity #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bm3p_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bm3p_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_kind,
    input  logic [PIXEL_BITS-1:0]            i_pixel_value,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [PIXEL_BITS-1:0]            o_mean_value,
    output logic                             o_row_end,
    output logic                             o_frame_end
);

    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 4;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [PIXEL_BITS-1:0] rd_data;
    bm3p_pkg::t_dp_ctl     dp_ctl;
    logic                  done;

    // position tracking and read sequencing
    bm3p_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .o_in_stall  (o_in_stall),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_dp        (dp_ctl),
        .i_done      (done)
    );

    // pixel history ring
    bm3p_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_pixel_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // sum, mean and output register
    bm3p_dp #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp         (dp_ctl),
        .i_rd_data    (rd_data),
        .o_done       (done),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_mean_value (o_mean_value),
        .o_row_end    (o_row_end),
        .o_frame_end  (o_frame_end)
    );

endmodule

@@ hdl/bm3p_checker.sv @@
// ----------------------------------------------------------------------------
// bm3p_checker
// Port-level checks for the 3x3 box mean block, attached by bind.
// ----------------------------------------------------------------------------
module bm3p_checker #(
    parameter int PIXEL_BITS = 8
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [PIXEL_BITS-1:0]            o_mean_value,
    input logic                             o_row_end,
    input logic                             o_frame_end
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_mean_value)
            && $stable(o_row_end) && $stable(o_frame_end)))
        else $error("stalled result changed");

    // last pixel of a frame is always last of its row
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    // one item at a time: an accepted item keeps the input stalled next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while another is at work");

    // a new result only appears while an item is at work
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no item at work");

endmodule

bind box_mean_3x3_parity bm3p_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_bm3p_checker (.*);

@@ tb/box_mean_checker.sv @@
// ----------------------------------------------------------------------------
// box_mean_checker
// Watches the configuration, input and result channels of the 3x3 box mean
// block, keeps its own copy of the stream position and pixel history,
// predicts each result when the item that releases it is taken, and compares
// every taken result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module box_mean_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [bm3p_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bm3p_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_kind,
    input  logic [PIXEL_BITS-1:0]            i_pixel_value,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [PIXEL_BITS-1:0]            i_mean_value,
    input  logic                             i_row_end,
    input  logic                             i_frame_end,
    output int                               o_fail_count,
    output int                               o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST = 2 * MAX_WIDTH + 4;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] mean;
        logic                  row_end;
        logic                  frame_end;
    } t_mean_item;

    // register copies
    logic [bm3p_pkg::WIDTH_FIELD_W-1:0] width_reg;
    logic [bm3p_pkg::HEIGHT_W-1:0]      height_reg;
    logic [bm3p_pkg::FILTER_W-1:0]      filter_reg;

    // stream position and pixel history
    logic [PIXEL_BITS-1:0] history [HIST];
    int                    wr_ptr;
    int                    backlog;
    int                    in_col;
    int                    in_row;
    int                    out_col;
    int                    out_row;

    t_mean_item mean_due_q[$];
    t_mean_item due;

    // any register write, and reset, start the stream afresh
    function automatic void restart_stream();
        foreach (history[k]) history[k] = '0;
        wr_ptr  = 0;
        backlog = 0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // store a pixel, then release the oldest pending mean if its
    // neighbourhood is complete
    function automatic void advance_stream(input logic kind,
                                           input logic [PIXEL_BITS-1:0] pix);
        int                    cols;
        int                    rows;
        int                    received;
        int                    centre;
        int                    total;
        int                    hits;
        int                    r;
        int                    c;
        int                    dr;
        int                    dc;
        logic [PIXEL_BITS-1:0] v;
        t_mean_item            res;
        cols = (width_reg == 0) ? 1 :
               (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        rows = (height_reg == 0) ? 1 : int'(height_reg);
        if (kind == bm3p_pkg::KIND_PIXEL) begin
            history[wr_ptr] = pix;
            wr_ptr  = (wr_ptr + 1) % HIST;
            backlog = backlog + 1;
            in_col  = in_col + 1;
            if (in_col >= cols) begin
                in_col = 0;
                in_row = in_row + 1;
                if (in_row >= rows) in_row = 0;
            end
        end
        received = in_row * cols + in_col;
        if (backlog == 0) return;
        // same frame still arriving: wait for the pixel one row and one column on
        if (backlog <= received && backlog < cols + 2) return;
        centre = (wr_ptr + HIST - backlog) % HIST;
        total  = 0;
        hits   = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                r = out_row + dr;
                c = out_col + dc;
                if (r >= 0 && r < rows && c >= 0 && c < cols) begin
                    v = history[(centre + 2 * HIST + dr * cols + dc) % HIST];
                    if (filter_reg == bm3p_pkg::FILT_ALL ||
                        (filter_reg == bm3p_pkg::FILT_EVEN && !v[0]) ||
                        (filter_reg == bm3p_pkg::FILT_ODD && v[0])) begin
                        total = total + int'(v);
                        hits  = hits + 1;
                    end
                end
            end
        end
        res.mean      = (hits != 0) ? PIXEL_BITS'(total / hits) : '0;
        res.row_end   = (out_col == cols - 1);
        res.frame_end = (out_col == cols - 1) && (out_row == rows - 1);
        mean_due_q    = {mean_due_q, res};
        backlog = backlog - 1;
        out_col = out_col + 1;
        if (out_col >= cols) begin
            out_col = 0;
            out_row = out_row + 1;
            if (out_row >= rows) out_row = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg    = bm3p_pkg::WIDTH_FIELD_W'(1024);
            height_reg   = bm3p_pkg::HEIGHT_W'(1024);
            filter_reg   = bm3p_pkg::FILT_ALL;
            restart_stream();
            mean_due_q.delete();
            o_fail_count = 0;
        end else begin
            // taken result against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (mean_due_q.size() == 0) begin
                    $error("result with nothing expected: mean_value %0d", i_mean_value);
                    o_fail_count++;
                end else begin
                    due = mean_due_q.pop_front();
                    if (i_mean_value !== due.mean) begin
                        $error("mean_value: expected %0d, got %0d", due.mean, i_mean_value);
                        o_fail_count++;
                    end
                    if (i_row_end !== due.row_end) begin
                        $error("row_end: expected %0b, got %0b", due.row_end, i_row_end);
                        o_fail_count++;
                    end
                    if (i_frame_end !== due.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               due.frame_end, i_frame_end);
                        o_fail_count++;
                    end
                end
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bm3p_pkg::CFG_WIDTH: begin
                        width_reg = i_cfg_data[bm3p_pkg::WIDTH_FIELD_W-1:0];
                        restart_stream();
                    end
                    bm3p_pkg::CFG_HEIGHT: begin
                        height_reg = i_cfg_data[bm3p_pkg::HEIGHT_W-1:0];
                        restart_stream();
                    end
                    bm3p_pkg::CFG_FILTER: begin
                        filter_reg = i_cfg_data[bm3p_pkg::FILTER_W-1:0];
                        restart_stream();
                    end
                    default: ;
                endcase
            end
            // taken input item
            if (i_in_valid && !i_in_stall) advance_stream(i_kind, i_pixel_value);
        end
        o_waiting = mean_due_q.size();
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the 3x3 box mean block: a short directed opening
// over extreme pixels, parity modes and degenerate frame sizes, then random
// frames of random size and mode, broken frames and stray drains, and two
// frames at the tallest height. Input bursts and result stalls are random;
// the checker module does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W = 1024;
    localparam int PIX_W = 8;
    localparam logic [bm3p_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                             clk        = 1'b0;
    logic                             rst_n      = 1'b0;
    logic                             cfg_valid  = 1'b0;
    logic                             cfg_ready;
    logic [bm3p_pkg::CFG_INDEX_W-1:0] cfg_index  = bm3p_pkg::CFG_WIDTH;
    logic [bm3p_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                             in_valid   = 1'b0;
    logic                             in_stall;
    logic                             in_kind    = bm3p_pkg::KIND_PIXEL;
    logic [PIX_W-1:0]                 in_pixel   = '0;
    logic                             out_valid;
    logic                             out_stall  = 1'b0;
    logic [PIX_W-1:0]                 mean_value;
    logic                             row_end;
    logic                             frame_end;
    int                               fail_count;
    int                               waiting;

    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    always #5 clk = ~clk;

    box_mean_3x3_parity #(.MAX_WIDTH(MAX_W), .PIXEL_BITS(PIX_W)) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (in_kind),
        .i_pixel_value (in_pixel),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_mean_value  (mean_value),
        .o_row_end     (row_end),
        .o_frame_end   (frame_end)
    );

    box_mean_checker #(.MAX_WIDTH(MAX_W), .PIXEL_BITS(PIX_W)) i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_kind        (in_kind),
        .i_pixel_value (in_pixel),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_mean_value  (mean_value),
        .i_row_end     (row_end),
        .i_frame_end   (frame_end),
        .o_fail_count  (fail_count),
        .o_waiting     (waiting)
    );

    // result stall pattern: free, half or heavy, switching every so often
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // one input item, in bursts with random gaps between them
    task automatic put_item(input logic kind, input logic [PIX_W-1:0] pix);
        int   gap;
        logic taken;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_pixel <= pix;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
    endtask

    // one register write; valid stays up for a following write
    task automatic set_reg(input logic [bm3p_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bm3p_pkg::CFG_DATA_W-1:0] data);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    // all three registers in a random order, now and then a spare index first
    task automatic configure(input logic [bm3p_pkg::CFG_DATA_W-1:0] wdata,
                             input logic [bm3p_pkg::CFG_DATA_W-1:0] hdata,
                             input logic [bm3p_pkg::CFG_DATA_W-1:0] fdata);
        logic [bm3p_pkg::CFG_INDEX_W-1:0] reg_order [3];
        int                               rot;
        reg_order[0] = bm3p_pkg::CFG_WIDTH;
        reg_order[1] = bm3p_pkg::CFG_HEIGHT;
        reg_order[2] = bm3p_pkg::CFG_FILTER;
        if ($urandom_range(0, 7) == 0) begin
            set_reg(CFG_SPARE, bm3p_pkg::CFG_DATA_W'($urandom));
        end
        rot = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            case (reg_order[(k + rot) % 3])
                bm3p_pkg::CFG_WIDTH:  set_reg(bm3p_pkg::CFG_WIDTH, wdata);
                bm3p_pkg::CFG_HEIGHT: set_reg(bm3p_pkg::CFG_HEIGHT, hdata);
                default:              set_reg(bm3p_pkg::CFG_FILTER, fdata);
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // wait until every predicted mean is out, then for the block to go quiet
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (waiting != 0);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        int                              cols;
        int                              rows;
        int                              total;
        int                              drains;
        int                              rand_px;
        int                              sel;
        logic [bm3p_pkg::CFG_DATA_W-1:0] wv;
        logic [bm3p_pkg::CFG_DATA_W-1:0] hv;
        logic [bm3p_pkg::FILTER_W-1:0]   fv;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // 3x2 frames, even values only: extremes, then a frame with no even pixel
        configure(16'd3, 16'd2, {14'd0, bm3p_pkg::FILT_EVEN});
        put_item(bm3p_pkg::KIND_PIXEL, 8'd0);
        put_item(bm3p_pkg::KIND_PIXEL, 8'd255);
        put_item(bm3p_pkg::KIND_PIXEL, 8'd254);
        put_item(bm3p_pkg::KIND_PIXEL, 8'd1);
        put_item(bm3p_pkg::KIND_PIXEL, 8'd128);
        put_item(bm3p_pkg::KIND_PIXEL, 8'd255);
        for (int k = 0; k < 6; k++) put_item(bm3p_pkg::KIND_PIXEL, 8'd255);
        // flush, with one drain too many
        for (int k = 0; k < 5; k++) put_item(bm3p_pkg::KIND_DRAIN, 8'(k * 60));

        // zero width and height act as one, filter value three counts nothing
        settle();
        configure(16'd0, 16'd0, {14'd0, bm3p_pkg::FILT_NONE});
        put_item(bm3p_pkg::KIND_PIXEL, 8'd200);
        put_item(bm3p_pkg::KIND_PIXEL, 8'd7);
        put_item(bm3p_pkg::KIND_DRAIN, 8'd255);
        put_item(bm3p_pkg::KIND_DRAIN, 8'd0);

        // random frames, mostly whole, some cut short, with stray drains
        rand_px = 0;
        while (rand_px < 950) begin
            wv = ($urandom_range(0, 9) == 0) ? 16'd0 :
                 16'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8));
            hv = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
            fv = bm3p_pkg::FILTER_W'($urandom_range(0, 3));
            cols  = (wv == 0) ? 1 : int'(wv);
            rows  = (hv == 0) ? 1 : int'(hv);
            total = $urandom_range(1, 3) * cols * rows;
            if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
            settle();
            configure(($urandom_range(0, 5) == 0) ? {5'($urandom), wv[10:0]} : wv, hv,
                      ($urandom_range(0, 5) == 0) ? {14'($urandom), fv} : {14'd0, fv});
            for (int p = 0; p < total; p++) begin
                if ($urandom_range(0, 19) == 0) begin
                    put_item(bm3p_pkg::KIND_DRAIN, 8'($urandom));
                end
                sel = $urandom_range(0, 7);
                put_item(bm3p_pkg::KIND_PIXEL,
                         (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom));
            end
            drains = cols + 1 + $urandom_range(0, 2);
            for (int d = 0; d < drains; d++) put_item(bm3p_pkg::KIND_DRAIN, 8'($urandom));
            rand_px += total;
        end

        // all-ones width and height: too few pixels for any result
        settle();
        configure(16'hFFFF, 16'hFFFF, {14'd0, bm3p_pkg::FILT_ALL});
        for (int p = 0; p < 30; p++) put_item(bm3p_pkg::KIND_PIXEL, 8'($urandom));
        put_item(bm3p_pkg::KIND_DRAIN, 8'($urandom));

        // tallest frame, two wide, even values only
        settle();
        configure(16'd2, 16'hFFFF, {14'd0, bm3p_pkg::FILT_EVEN});
        for (int p = 0; p < 80; p++) put_item(bm3p_pkg::KIND_PIXEL, 8'($urandom));
        for (int d = 0; d < 4; d++) put_item(bm3p_pkg::KIND_DRAIN, 8'($urandom));

        settle();
        if (fail_count == 0 && waiting == 0) begin
            $display("box_mean_3x3_parity verification clean");
        end else begin
            $display("box_mean_3x3_parity verification failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #8_000_000;
        $display("box_mean_3x3_parity verification failed");
        $finish;
    end

endmodule

@@ box_mean_3x3_parity.f @@
hdl/bm3p_pkg.sv
hdl/bm3p_ram.sv
hdl/bm3p_ctrl.sv
hdl/bm3p_dp.sv
hdl/box_mean_3x3_parity.sv
hdl/bm3p_checker.sv
tb/box_mean_checker.sv
tb/tb.sv
